@@ hw/rtl/sira_pkg.sv @@
// Shared types and constants for the sliced ID range allocator.
package sira_pkg;

    localparam logic MODE_INIT  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_TOO_BIG = 1'b1;

    localparam logic [7:0] MAX_MULT  = 8'd255;
    localparam logic [2:0] MAX_SHIFT = 3'd7;
    localparam logic [2:0] SHIFT_RST = 3'd1;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 32;

    // one row of the per-group table
    typedef struct packed {
        logic [31:0] next_id;
        logic [7:0]  used;
        logic [7:0]  mult;
    } grp_ent_t;

    // one input word after unpacking
    typedef struct packed {
        logic        mode;
        logic [3:0]  group;
        logic [21:0] req_size;
        logic [31:0] now_seconds;
    } item_t;

    // state update produced for one word
    typedef struct packed {
        logic        wr;
        grp_ent_t    ent;
        logic [31:0] base;
        logic [2:0]  shift;
    } upd_t;

endpackage

@@ hw/rtl/sira_tbl.sv @@
// Per-group table: RAM with registered read, per-entry valid bits and write bypass.
module sira_tbl #(
    parameter int NUM_GROUPS = 16,
    parameter int AW         = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  sira_pkg::grp_ent_t wr_data,
    output sira_pkg::grp_ent_t rd_data
);
    import sira_pkg::*;

    grp_ent_t              mem [NUM_GROUPS];
    logic [NUM_GROUPS-1:0] vld_reg;
    grp_ent_t              raw_reg;
    grp_ent_t              byp_reg;
    logic                  byp_sel_reg;
    logic                  vld_sel_reg;
    logic                  in_rng_rd;
    logic                  in_rng_wr;

    assign in_rng_rd = ({1'b0, rd_addr} < (AW+1)'(NUM_GROUPS));
    assign in_rng_wr = ({1'b0, wr_addr} < (AW+1)'(NUM_GROUPS));

    always_ff @(posedge clk)
    begin
        if (wr_en && in_rng_wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            if (in_rng_rd)
            begin
                raw_reg <= mem[rd_addr];
            end
            byp_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            byp_sel_reg <= 1'b0;
            vld_sel_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && in_rng_wr)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                // a write landing on the same row this cycle wins
                byp_sel_reg <= wr_en && (wr_addr == rd_addr);
                vld_sel_reg <= in_rng_rd && vld_reg[rd_addr];
            end
        end
    end

    always_comb
    begin
        if (byp_sel_reg)
        begin
            rd_data = byp_reg;
        end
        else if (vld_sel_reg)
        begin
            rd_data = raw_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

@@ hw/rtl/sira_alu.sv @@
// Single-pass datapath: init/alloc decision, range take and counter restart.
module sira_alu #(
    parameter int SLICE_BITS = 14
) (
    input  sira_pkg::item_t    item,
    input  sira_pkg::grp_ent_t ent,
    input  logic [31:0]        base,
    input  logic [2:0]         shift,
    output logic [31:0]        id_value,
    output logic               status,
    output sira_pkg::upd_t     upd
);
    import sira_pkg::*;

    localparam logic [31:0] SLICE_MASK = 32'((64'd1 << SLICE_BITS) - 64'd1);

    function automatic logic [31:0] align_up(input logic [31:0] v);
        logic [32:0] t;
        t = {1'b0, v} + {1'b0, SLICE_MASK};
        return t[31:0] & ~SLICE_MASK;
    endfunction

    logic        is_init;
    logic        too_big;
    logic [31:0] size32;
    logic [31:0] ceil_w;
    logic [7:0]  mult_i;
    logic [7:0]  mult_t;
    logic [31:0] base_eff;
    logic [31:0] nxt;
    logic        boundary;
    logic [7:0]  used_inc;
    logic        take;
    logic [32:0] sum;
    logic        wrap;
    logic [31:0] wrap_base;

    always_comb
    begin
        is_init   = (item.mode == MODE_INIT);
        size32    = 32'(item.req_size);
        too_big   = size32 > (32'(MAX_MULT) << SLICE_BITS);
        ceil_w    = (size32 + SLICE_MASK) >> SLICE_BITS;
        mult_i    = (item.req_size == '0) ? 8'd1 : ceil_w[7:0];
        base_eff  = (is_init && base == '0) ? align_up(item.now_seconds) : base;

        nxt       = ent.next_id + 32'd1;
        boundary  = (nxt & SLICE_MASK) == '0;
        used_inc  = ent.used + 8'd1;

        take      = is_init ? !too_big : (boundary && used_inc == ent.mult);
        mult_t    = is_init ? mult_i : ent.mult;
        sum       = {1'b0, base_eff} + (33'(mult_t) << SLICE_BITS);
        // reaching 2^31, or carrying out of 32 bits
        wrap      = sum[32] | sum[31];
        wrap_base = align_up(item.now_seconds >> shift);

        upd.wr    = !(is_init && too_big);
        upd.shift = shift;
        if (take)
        begin
            upd.ent.next_id = base_eff;
            upd.ent.used    = 8'd0;
            upd.ent.mult    = mult_t;
            if (wrap)
            begin
                upd.base = wrap_base;
                if (shift < MAX_SHIFT)
                begin
                    upd.shift = shift + 3'd1;
                end
            end
            else
            begin
                upd.base = sum[31:0];
            end
        end
        else
        begin
            upd.ent.next_id = nxt;
            upd.ent.used    = boundary ? used_inc : ent.used;
            upd.ent.mult    = ent.mult;
            upd.base        = base_eff;
        end

        id_value = is_init ? 32'd0 : ent.next_id;
        status   = (is_init && too_big) ? STAT_TOO_BIG : STAT_OK;
    end

endmodule

@@ hw/rtl/sliced_id_range_allocator_core.sv @@
// Table read and input register load on the accept edge; the ALU then computes into
// the result register when that stage advances. Throughput: one word per cycle
// unless m_tready stalls the output; the per-group table read is registered and a
// same-row write from the word ahead is bypassed, so back-to-back words to one group run.
// Reset: async active-low; group table reads as zero (valid bits cleared), shared
// base cleared, start shift set to 1, pipeline emptied. No clearing pass.
module sliced_id_range_allocator_core #(
    parameter int NUM_GROUPS = 16,
    parameter int SLICE_BITS = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [3:0] group, [25:4] req_size, [57:26] now_seconds, [63:58] zero
    input  logic [sira_pkg::IN_DATA_W-1:0]    s_tdata,
    // [0] mode
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] id_value
    output logic [sira_pkg::OUT_DATA_W-1:0]   m_tdata,
    // [0] status
    output logic                              m_tuser
);
    import sira_pkg::*;

    localparam int AW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

    item_t       in_item;
    item_t       s1_item_reg;
    logic        s1_vld_reg;
    logic [31:0] base_reg;
    logic [2:0]  shift_reg;
    logic        out_vld_reg;
    logic [31:0] out_id_reg;
    logic        out_stat_reg;

    logic        s_acc;
    logic        adv;
    logic        in_rng;
    logic [AW+3:0] s1_grp_ext;
    logic [AW+3:0] in_grp_ext;
    grp_ent_t    rd_ent;
    logic [31:0] alu_id;
    logic        alu_stat;
    upd_t        upd;
    logic        do_wr;

    assign in_item.mode        = s_tuser;
    assign in_item.group       = s_tdata[3:0];
    assign in_item.req_size    = s_tdata[25:4];
    assign in_item.now_seconds = s_tdata[57:26];

    assign adv      = s1_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !s1_vld_reg || adv;
    assign s_acc    = s_tvalid && s_tready;

    assign s1_grp_ext = {AW'(0), s1_item_reg.group};
    assign in_grp_ext = {AW'(0), in_item.group};
    assign in_rng     = s1_grp_ext < (AW+4)'(NUM_GROUPS);
    assign do_wr      = adv && in_rng && upd.wr;

    sira_tbl #(
        .NUM_GROUPS (NUM_GROUPS),
        .AW         (AW)
    ) u_tbl (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (s_acc),
        .rd_addr (in_grp_ext[AW-1:0]),
        .wr_en   (do_wr),
        .wr_addr (s1_grp_ext[AW-1:0]),
        .wr_data (upd.ent),
        .rd_data (rd_ent)
    );

    sira_alu #(
        .SLICE_BITS (SLICE_BITS)
    ) u_alu (
        .item     (s1_item_reg),
        .ent      (rd_ent),
        .base     (base_reg),
        .shift    (shift_reg),
        .id_value (alu_id),
        .status   (alu_stat),
        .upd      (upd)
    );

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_item_reg <= in_item;
        end
        if (adv)
        begin
            out_id_reg   <= in_rng ? alu_id : 32'd0;
            out_stat_reg <= in_rng ? alu_stat : STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            base_reg    <= '0;
            shift_reg   <= SHIFT_RST;
        end
        else
        begin
            if (s_tready)
            begin
                s1_vld_reg <= s_tvalid;
            end
            if (adv)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (do_wr)
            begin
                base_reg  <= upd.base;
                shift_reg <= upd.shift;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = out_stat_reg;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the sliced ID range allocator core.
module tb_top;
    import sira_pkg::*;

    localparam int NUM_GROUPS = 16;
    localparam int SLICE_BITS = 14;
    localparam logic [63:0] SLICE_LEN = 64'd1 << SLICE_BITS;
    localparam logic [63:0] WRAP_LIMIT = 64'h8000_0000;
    localparam logic [21:0] MAX_OK_SIZE = 22'(SLICE_LEN * MAX_MULT);
    localparam int MAX_REPORTS = 100;

    // tracks group table and shared base, queues the expected result words
    class id_range_tracker;
        logic [31:0] grp_next [NUM_GROUPS];
        logic [7:0]  grp_used [NUM_GROUPS];
        logic [7:0]  grp_mult [NUM_GROUPS];
        logic [31:0] next_base;
        logic [2:0]  start_shift;
        logic [31:0] exp_ids [$];
        logic        exp_status [$];
        int          mismatches;

        function new();
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                grp_next[g] = '0;
                grp_used[g] = '0;
                grp_mult[g] = '0;
            end
            next_base   = '0;
            start_shift = SHIFT_RST;
            mismatches  = 0;
        endfunction

        function logic [31:0] align_up(logic [63:0] v);
            return 32'((v + SLICE_LEN - 64'd1) & ~(SLICE_LEN - 64'd1));
        endfunction

        function void take_range(int g, logic [31:0] now_s);
            logic [63:0] span_end;
            grp_next[g] = next_base;
            span_end = {32'd0, next_base} + ({56'd0, grp_mult[g]} << SLICE_BITS);
            // compare at full width: a 32-bit carry also counts as reaching the limit
            if (span_end >= WRAP_LIMIT)
            begin
                next_base = align_up({32'd0, now_s >> start_shift});
                if (start_shift < MAX_SHIFT)
                    start_shift = start_shift + 3'd1;
            end
            else
                next_base = span_end[31:0];
        endfunction

        function void note_word(logic mode, logic [3:0] grp, logic [21:0] size,
                                logic [31:0] now_s);
            logic [31:0] id;
            logic [31:0] nxt;
            logic [63:0] req;
            logic [7:0]  mult;
            if (int'(grp) >= NUM_GROUPS)
            begin
                exp_ids.push_back('0);
                exp_status.push_back(STAT_OK);
                return;
            end
            if (mode == MODE_INIT)
            begin
                req = {42'd0, size};
                if (req > SLICE_LEN * MAX_MULT)
                begin
                    exp_ids.push_back('0);
                    exp_status.push_back(STAT_TOO_BIG);
                    return;
                end
                if (next_base == '0)
                    next_base = align_up({32'd0, now_s});
                if (req < SLICE_LEN)
                    mult = 8'd1;
                else
                    mult = 8'((req + SLICE_LEN - 64'd1) >> SLICE_BITS);
                grp_mult[grp] = mult;
                take_range(int'(grp), now_s);
                grp_used[grp] = '0;
                exp_ids.push_back('0);
                exp_status.push_back(STAT_OK);
            end
            else
            begin
                id = grp_next[grp];
                nxt = id + 32'd1;
                grp_next[grp] = nxt;
                if (nxt[SLICE_BITS-1:0] == '0)
                begin
                    grp_used[grp] = grp_used[grp] + 8'd1;
                    if (grp_used[grp] == grp_mult[grp])
                    begin
                        take_range(int'(grp), now_s);
                        grp_used[grp] = '0;
                    end
                end
                exp_ids.push_back(id);
                exp_status.push_back(STAT_OK);
            end
        endfunction

        function void check_word(logic [31:0] id, logic stat);
            logic [31:0] want_id;
            logic        want_stat;
            if (exp_ids.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected word: id %h status %0b", $time, id, stat);
                return;
            end
            want_id   = exp_ids.pop_front();
            want_stat = exp_status.pop_front();
            if (id !== want_id)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: id_value expected %h, got %h", $time, want_id, id);
            end
            if (stat !== want_stat)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: status expected %0b, got %0b", $time, want_stat, stat);
            end
        endfunction

        function int pending();
            return exp_ids.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    bit tx_gaps = 1'b1;
    bit rx_stalls = 1'b1;

    id_range_tracker tracker;

    sliced_id_range_allocator_core #(
        .NUM_GROUPS(NUM_GROUPS),
        .SLICE_BITS(SLICE_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #1 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // mostly short gaps, a few long ones
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function logic [21:0] rand_size();
        case ($urandom_range(0, 5))
            0: return 22'($urandom);
            1: return '0;
            2: return 22'($urandom_range(1, 65535));
            3: return 22'($urandom_range(1, 255) << SLICE_BITS);
            4: return 22'($urandom_range(int'(MAX_OK_SIZE) + 1, 22'h3F_FFFF));
            default: return 22'($urandom_range(0, int'(MAX_OK_SIZE)));
        endcase
    endfunction

    function logic [31:0] rand_now();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 65535);
            1: return 32'hFFFF_0000 | $urandom_range(0, 65535);
            2: return 32'h7FFF_0000 + $urandom_range(0, 131071);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(logic mode, logic [3:0] grp, logic [21:0] size,
                             logic [31:0] now_s);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, now_s, size, grp};
        s_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_tready);
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(int alloc_pct, bit big_inits);
        logic [21:0] size;
        if ($urandom_range(0, 99) < alloc_pct)
            send_word(MODE_ALLOC, 4'($urandom), 22'($urandom), rand_now());
        else
        begin
            if (big_inits && $urandom_range(0, 9) != 0)
                size = 22'($urandom_range(int'(MAX_OK_SIZE) - int'(SLICE_LEN) + 1,
                                          int'(MAX_OK_SIZE)));
            else
                size = rand_size();
            send_word(MODE_INIT, 4'($urandom), size, rand_now());
        end
    endtask

    // receiver side back-pressure
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (rx_stalls && $urandom_range(0, 99) < 20)
            begin
                n = pick_gap() + 1;
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            tracker.note_word(s_tuser, s_tdata[3:0], s_tdata[25:4], s_tdata[57:26]);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_word(m_tdata, m_tuser);
    end

    initial
    begin
        tracker = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // uninitialized group hands out IDs from zero
        send_word(MODE_ALLOC, 4'd3, 22'd0, 32'd0);
        send_word(MODE_ALLOC, 4'd3, 22'h3F_FFFF, 32'hFFFF_FFFF);
        // oversize requests leave state alone
        send_word(MODE_INIT, 4'd1, 22'h3F_FFFF, 32'h1234_5678);
        send_word(MODE_INIT, 4'd1, MAX_OK_SIZE + 22'd1, 32'd0);
        // first seed near the top: 32-bit carry forces a restart
        send_word(MODE_INIT, 4'd2, 22'd0, 32'hFFFF_C000);
        // base at 2^31 restarts again; seconds of zero clears the base
        send_word(MODE_INIT, 4'd4, MAX_OK_SIZE, 32'd0);
        // reseed that aligns to zero
        send_word(MODE_INIT, 4'd7, 22'd0, 32'hFFFF_FFFF);
        send_word(MODE_INIT, 4'd6, 22'd1, 32'h0001_2345);
        send_word(MODE_INIT, 4'd8, 22'(SLICE_LEN), 32'd77);
        send_word(MODE_INIT, 4'd9, 22'(SLICE_LEN) + 22'd1, 32'd5);
        send_word(MODE_INIT, 4'd10, MAX_OK_SIZE - 22'd1, 32'h8000_0000);
        send_word(MODE_INIT, 4'd15, MAX_OK_SIZE, 32'h7FFF_FFFF);
        send_word(MODE_ALLOC, 4'd15, 22'd0, 32'd0);
        send_word(MODE_ALLOC, 4'd0, 22'd0, 32'd0);
        send_word(MODE_ALLOC, 4'd6, 22'd0, 32'd0);
        send_word(MODE_ALLOC, 4'd6, 22'd0, 32'd0);
        send_word(MODE_ALLOC, 4'd2, 22'd0, 32'd0);

        for (int i = 0; i < 280; i++)
        begin
            tx_gaps = ((i / 50) % 3) != 2;
            rx_stalls = ((i / 50) % 4) != 3;
            send_random(70, 1'b0);
        end

        // big inits push the shared base toward a restart
        for (int i = 0; i < 100; i++)
        begin
            tx_gaps = i >= 50;
            rx_stalls = i >= 25;
            send_random(15, 1'b1);
        end

        s_tvalid <= 1'b0;
        for (int i = 0; i < 2000 && tracker.pending() != 0; i++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.pending() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, tracker.pending());
            tracker.mismatches++;
        end

        if (tracker.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
